// ===== rtl/tree_ancestor_lca_engine_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the LCA engine
// Shared forms for the concurrent checks; bodies sample on clk and are
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TREE_ANCESTOR_LCA_ENGINE_CORE_DEFINES_SVH
`define TREE_ANCESTOR_LCA_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define TALCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TALCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/talca_pkg.sv =====
// ---------------------------------------------------------------------------
// LCA engine package
// Field widths, sequencer step codes, control word layout and the
// microprogram table.
// ---------------------------------------------------------------------------
package talca_pkg;

	localparam int NODE_W = 10;
	localparam int DEP_W  = 10;
	localparam int ENC_W  = 11;
	localparam int DIST_W = 11;

	localparam logic [DEP_W-1:0]  DEPTH_MAX = DEP_W'(1023);
	localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(2046);

	localparam int PC_W  = 5;
	localparam int OP_W  = 5;
	localparam int CND_W = 4;

	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [OP_W-1:0]  op_t;
	typedef logic [CND_W-1:0] cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   tgt_t;
		pc_t   tgt_f;
	} ucode_t;

	// sequencer steps
	localparam pc_t PC_IDLE       = 5'd0;
	localparam pc_t PC_DISPATCH   = 5'd1;
	localparam pc_t PC_I_CHECK    = 5'd2;
	localparam pc_t PC_I_ROOT     = 5'd3;
	localparam pc_t PC_I_FILL_RD  = 5'd4;
	localparam pc_t PC_I_FILL_WR  = 5'd5;
	localparam pc_t PC_Q_START    = 5'd6;
	localparam pc_t PC_Q_RDB      = 5'd7;
	localparam pc_t PC_Q_ORDER    = 5'd8;
	localparam pc_t PC_Q_LIFT_RD  = 5'd9;
	localparam pc_t PC_Q_LIFT_WB  = 5'd10;
	localparam pc_t PC_Q_LIFT_SKP = 5'd11;
	localparam pc_t PC_Q_POST     = 5'd12;
	localparam pc_t PC_Q_EQ       = 5'd13;
	localparam pc_t PC_Q_DESC_RD  = 5'd14;
	localparam pc_t PC_Q_DESC_UP  = 5'd15;
	localparam pc_t PC_Q_DESC_END = 5'd16;
	localparam pc_t PC_Q_DESC_ANC = 5'd17;
	localparam pc_t PC_Q_ANC_CHK  = 5'd18;
	localparam pc_t PC_Q_DIST     = 5'd19;
	localparam pc_t PC_FINISH     = 5'd20;
	localparam pc_t PC_Q_NF       = 5'd21;

	// datapath operations
	localparam op_t OP_NOP        = 5'd0;
	localparam op_t OP_I_RDDEP    = 5'd1;
	localparam op_t OP_I_ROOT     = 5'd2;
	localparam op_t OP_RD_X       = 5'd3;
	localparam op_t OP_I_FILL     = 5'd4;
	localparam op_t OP_Q_RDA      = 5'd5;
	localparam op_t OP_Q_RDB      = 5'd6;
	localparam op_t OP_Q_ORDER    = 5'd7;
	localparam op_t OP_HOP_X      = 5'd8;
	localparam op_t OP_LVL_DEC    = 5'd9;
	localparam op_t OP_Q_EQ       = 5'd10;
	localparam op_t OP_RD_XY      = 5'd11;
	localparam op_t OP_DESC       = 5'd12;
	localparam op_t OP_RD_ANC     = 5'd13;
	localparam op_t OP_ANC        = 5'd14;
	localparam op_t OP_RD_ANCDEP  = 5'd15;
	localparam op_t OP_DIST       = 5'd16;
	localparam op_t OP_NF         = 5'd17;
	localparam op_t OP_FINISH     = 5'd18;

	// jump conditions
	localparam cond_t C_ALWAYS     = 4'd0;
	localparam cond_t C_IN_ACC     = 4'd1;
	localparam cond_t C_QUERY      = 4'd2;
	localparam cond_t C_A_BAD      = 4'd3;
	localparam cond_t C_QRANGE_BAD = 4'd4;
	localparam cond_t C_LVL_LAST   = 4'd5;
	localparam cond_t C_EX_ZERO    = 4'd6;
	localparam cond_t C_NEED_HOP   = 4'd7;
	localparam cond_t C_LVL_NZ     = 4'd8;
	localparam cond_t C_LIFT_CONT  = 4'd9;
	localparam cond_t C_EQ         = 4'd10;
	localparam cond_t C_ANC_BAD    = 4'd11;
	localparam cond_t C_OUT_FREE   = 4'd12;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			PC_IDLE:       w = '{OP_NOP,       C_IN_ACC,     PC_DISPATCH,   PC_IDLE};
			PC_DISPATCH:   w = '{OP_NOP,       C_QUERY,      PC_Q_START,    PC_I_CHECK};
			PC_I_CHECK:    w = '{OP_I_RDDEP,   C_A_BAD,      PC_FINISH,     PC_I_ROOT};
			PC_I_ROOT:     w = '{OP_I_ROOT,    C_ALWAYS,     PC_I_FILL_RD,  PC_I_FILL_RD};
			PC_I_FILL_RD:  w = '{OP_RD_X,      C_LVL_LAST,   PC_FINISH,     PC_I_FILL_WR};
			PC_I_FILL_WR:  w = '{OP_I_FILL,    C_ALWAYS,     PC_I_FILL_RD,  PC_I_FILL_RD};
			PC_Q_START:    w = '{OP_Q_RDA,     C_QRANGE_BAD, PC_Q_NF,       PC_Q_RDB};
			PC_Q_RDB:      w = '{OP_Q_RDB,     C_ALWAYS,     PC_Q_ORDER,    PC_Q_ORDER};
			PC_Q_ORDER:    w = '{OP_Q_ORDER,   C_ALWAYS,     PC_Q_LIFT_RD,  PC_Q_LIFT_RD};
			PC_Q_LIFT_RD:  w = '{OP_RD_X,      C_NEED_HOP,   PC_Q_LIFT_WB,  PC_Q_LIFT_SKP};
			PC_Q_LIFT_WB:  w = '{OP_HOP_X,     C_LIFT_CONT,  PC_Q_LIFT_RD,  PC_Q_POST};
			PC_Q_LIFT_SKP: w = '{OP_LVL_DEC,   C_LVL_NZ,     PC_Q_LIFT_RD,  PC_Q_POST};
			PC_Q_POST:     w = '{OP_NOP,       C_EX_ZERO,    PC_Q_NF,       PC_Q_EQ};
			PC_Q_EQ:       w = '{OP_Q_EQ,      C_EQ,         PC_Q_ANC_CHK,  PC_Q_DESC_RD};
			PC_Q_DESC_RD:  w = '{OP_RD_XY,     C_ALWAYS,     PC_Q_DESC_UP,  PC_Q_DESC_UP};
			PC_Q_DESC_UP:  w = '{OP_DESC,      C_LVL_NZ,     PC_Q_DESC_RD,  PC_Q_DESC_END};
			PC_Q_DESC_END: w = '{OP_RD_ANC,    C_ALWAYS,     PC_Q_DESC_ANC, PC_Q_DESC_ANC};
			PC_Q_DESC_ANC: w = '{OP_ANC,       C_ALWAYS,     PC_Q_ANC_CHK,  PC_Q_ANC_CHK};
			PC_Q_ANC_CHK:  w = '{OP_RD_ANCDEP, C_ANC_BAD,    PC_Q_NF,       PC_Q_DIST};
			PC_Q_DIST:     w = '{OP_DIST,      C_ALWAYS,     PC_FINISH,     PC_FINISH};
			PC_FINISH:     w = '{OP_FINISH,    C_OUT_FREE,   PC_IDLE,       PC_FINISH};
			PC_Q_NF:       w = '{OP_NF,        C_ALWAYS,     PC_FINISH,     PC_FINISH};
			default:       w = '{OP_NOP,       C_ALWAYS,     PC_IDLE,       PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/tree_ancestor_lca_engine_core.sv =====
// ---------------------------------------------------------------------------
// Binary-lifting lowest common ancestor engine
// Request channel (in_valid/in_stall): action 0 inserts node_a under node_b
// (root when has_parent is 0), parent first; action 1 queries node_a, node_b.
// Response channel (out_valid/out_stall): one response per request, in order.
// One request is worked at a time by a microcoded sequencer over a dual-read
// jump table memory and a depth memory; in_stall is high while it runs.
// Query lifting repeats the top-level jump while the remaining depth gap
// reaches 2^LIFT_LEVELS. A finished response waits in an output register;
// while out_stall is high and a response is still held, the sequencer holds
// in its finish step and the response stays unchanged.
// Reset returns the sequencer to idle and drops out_valid; the tables are
// not cleared, so nodes must be inserted before they are queried.
// ---------------------------------------------------------------------------
`include "tree_ancestor_lca_engine_core_defines.svh"

module tree_ancestor_lca_engine_core #(
	parameter int NODES       = 1024,
	parameter int LIFT_LEVELS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [talca_pkg::NODE_W-1:0] node_a,
	input  logic [talca_pkg::NODE_W-1:0] node_b,
	input  logic                         has_parent,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         kind,
	output logic [talca_pkg::NODE_W-1:0] ancestor,
	output logic [talca_pkg::DIST_W-1:0] distance,
	output logic                         not_found
);
	import talca_pkg::*;

	localparam int AW       = $clog2(NODES);
	localparam int LW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int JAW      = AW + LW;
	localparam int JT_DEPTH = 2 ** JAW;
	localparam int DIFF_W   = DIST_W + 1;
	localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

	// sequencer
	pc_t    pc_q;
	ucode_t uw;
	logic   cond_hit;
	logic   accept;
	logic   out_free;

	// request and work registers
	logic              act_q;
	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic              hp_q;
	logic [ENC_W-1:0]  ex_q;
	logic [ENC_W-1:0]  ey_q;
	logic [ENC_W-1:0]  anc_q;
	logic [DEP_W-1:0]  steps_q;
	logic [LW-1:0]     lvl_q;
	logic [DEP_W-1:0]  da_q;
	logic [DEP_W-1:0]  db_q;
	logic [NODE_W-1:0] res_anc_q;
	logic [DIST_W-1:0] res_dist_q;
	logic              res_nf_q;

	// response register
	logic              out_valid_q;
	logic              kind_q;
	logic [NODE_W-1:0] ancestor_q;
	logic [DIST_W-1:0] distance_q;
	logic              not_found_q;

	// memories
	logic [ENC_W-1:0] jt_mem [JT_DEPTH];
	logic [DEP_W-1:0] dp_mem [NODES];
	logic [ENC_W-1:0] jt_rda_q;
	logic [ENC_W-1:0] jt_rdb_q;
	logic [DEP_W-1:0] dp_rd_q;
	logic [JAW-1:0]   jt_raddr_a;
	logic [JAW-1:0]   jt_raddr_b;
	logic             jt_we;
	logic [JAW-1:0]   jt_waddr;
	logic [ENC_W-1:0] jt_wdata;
	logic [AW-1:0]    dp_raddr;
	logic             dp_we;
	logic [AW-1:0]    dp_waddr;
	logic [DEP_W-1:0] dp_wdata;

	// datapath terms
	logic              a_bad;
	logic              b_bad;
	logic              parent_ok;
	logic [AW-1:0]     a_node;
	logic [AW-1:0]     b_node;
	logic [AW-1:0]     ex_node;
	logic [AW-1:0]     ey_node;
	logic [AW-1:0]     anc_node;
	logic [ENC_W-1:0]  a_enc;
	logic [ENC_W-1:0]  b_enc;
	logic [ENC_W-1:0]  root_enc;
	logic [DEP_W-1:0]  root_dep;
	logic [DEP_W-1:0]  pow_lvl;
	logic              need_hop;
	logic              stay;
	logic              lvl_nz;
	logic [ENC_W-1:0]  rda_val;
	logic [ENC_W-1:0]  rdb_val;
	logic              anc_bad;
	logic [DIFF_W-1:0] dist_raw;
	logic [DIST_W-1:0] dist_sat;

	assign uw       = ucode_rom(pc_q);
	assign in_stall = (pc_q != PC_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign a_bad     = (32'(a_q) >= 32'(NODES));
	assign b_bad     = (32'(b_q) >= 32'(NODES));
	assign parent_ok = hp_q && !b_bad;
	assign a_node    = AW'(a_q);
	assign b_node    = AW'(b_q);
	assign ex_node   = AW'(ex_q - ENC_W'(1));
	assign ey_node   = AW'(ey_q - ENC_W'(1));
	assign anc_node  = AW'(anc_q - ENC_W'(1));
	assign a_enc     = ENC_W'(a_q) + ENC_W'(1);
	assign b_enc     = ENC_W'(b_q) + ENC_W'(1);
	assign root_enc  = parent_ok ? b_enc : '0;
	assign root_dep  = !parent_ok ? '0 :
		(dp_rd_q == DEPTH_MAX) ? DEPTH_MAX : dp_rd_q + DEP_W'(1);

	assign pow_lvl  = DEP_W'(1) << lvl_q;
	assign need_hop = (ex_q != '0) && ((steps_q >> lvl_q) != '0);
	// a gap of twice the top jump or more repeats the top level
	assign stay     = (lvl_q == LVL_TOP) && ((steps_q >> LIFT_LEVELS) != '0);
	assign lvl_nz   = (lvl_q != '0);

	// a hop from "no ancestor" stays at "no ancestor"
	assign rda_val = (ex_q == '0) ? '0 : jt_rda_q;
	assign rdb_val = (ey_q == '0) ? '0 : jt_rdb_q;
	assign anc_bad = (anc_q == '0) || (ex_q == '0) || (ey_q == '0);

	assign dist_raw = DIFF_W'(da_q) + DIFF_W'(db_q) - {1'b0, dp_rd_q, 1'b0};
	assign dist_sat = dist_raw[DIFF_W-1] ? '0 :
		(dist_raw[DIST_W-1:0] > DIST_MAX) ? DIST_MAX : dist_raw[DIST_W-1:0];

	always_comb begin
		case (uw.cond)
			C_ALWAYS:     cond_hit = 1'b1;
			C_IN_ACC:     cond_hit = accept;
			C_QUERY:      cond_hit = act_q;
			C_A_BAD:      cond_hit = a_bad;
			C_QRANGE_BAD: cond_hit = a_bad || b_bad;
			C_LVL_LAST:   cond_hit = (lvl_q == LVL_TOP);
			C_EX_ZERO:    cond_hit = (ex_q == '0);
			C_NEED_HOP:   cond_hit = need_hop;
			C_LVL_NZ:     cond_hit = lvl_nz;
			C_LIFT_CONT:  cond_hit = stay || lvl_nz;
			C_EQ:         cond_hit = (ex_q == ey_q);
			C_ANC_BAD:    cond_hit = anc_bad;
			C_OUT_FREE:   cond_hit = out_free;
			default:      cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		jt_raddr_a = {ex_node, lvl_q};
		jt_raddr_b = {ey_node, lvl_q};
		jt_we      = 1'b0;
		jt_waddr   = {a_node, lvl_q + LW'(1)};
		jt_wdata   = rda_val;
		dp_raddr   = a_node;
		dp_we      = 1'b0;
		dp_waddr   = a_node;
		dp_wdata   = root_dep;
		case (uw.op)
			OP_I_RDDEP:   dp_raddr = b_node;
			OP_I_ROOT: begin
				dp_we    = 1'b1;
				jt_we    = 1'b1;
				jt_waddr = {a_node, LW'(0)};
				jt_wdata = root_enc;
			end
			OP_I_FILL:    jt_we = 1'b1;
			OP_Q_RDA:     dp_raddr = a_node;
			OP_Q_RDB:     dp_raddr = b_node;
			OP_RD_ANC:    jt_raddr_a = {ex_node, LW'(0)};
			OP_RD_ANCDEP: dp_raddr = anc_node;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		jt_rda_q <= jt_mem[jt_raddr_a];
		jt_rdb_q <= jt_mem[jt_raddr_b];
		if (jt_we) begin
			jt_mem[jt_waddr] <= jt_wdata;
		end
	end

	always_ff @(posedge clk) begin
		dp_rd_q <= dp_mem[dp_raddr];
		if (dp_we) begin
			dp_mem[dp_waddr] <= dp_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_hit ? uw.tgt_t : uw.tgt_f;
			if (uw.op == OP_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action;
			a_q        <= node_a;
			b_q        <= node_b;
			hp_q       <= has_parent;
			res_anc_q  <= '0;
			res_dist_q <= '0;
			res_nf_q   <= 1'b0;
		end
		case (uw.op)
			OP_I_ROOT: begin
				ex_q  <= root_enc;
				lvl_q <= '0;
			end
			OP_I_FILL: begin
				ex_q  <= rda_val;
				lvl_q <= lvl_q + LW'(1);
			end
			OP_Q_RDB:     da_q <= dp_rd_q;
			OP_Q_ORDER: begin
				// lift the deeper node
				db_q  <= dp_rd_q;
				lvl_q <= LVL_TOP;
				if (da_q < dp_rd_q) begin
					ex_q    <= b_enc;
					ey_q    <= a_enc;
					steps_q <= dp_rd_q - da_q;
				end else begin
					ex_q    <= a_enc;
					ey_q    <= b_enc;
					steps_q <= da_q - dp_rd_q;
				end
			end
			OP_HOP_X: begin
				ex_q    <= jt_rda_q;
				steps_q <= steps_q - pow_lvl;
				if (!stay && lvl_nz) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			OP_LVL_DEC: begin
				if (lvl_nz) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			OP_Q_EQ: begin
				anc_q <= ex_q;
				lvl_q <= LVL_TOP;
			end
			OP_DESC: begin
				if (rda_val != rdb_val) begin
					ex_q <= rda_val;
					ey_q <= rdb_val;
				end
				if (lvl_nz) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			OP_ANC:       anc_q <= rda_val;
			OP_DIST: begin
				res_anc_q  <= NODE_W'(anc_q - ENC_W'(1));
				res_dist_q <= dist_sat;
			end
			OP_NF:        res_nf_q <= 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.op == OP_FINISH && out_free) begin
			kind_q      <= act_q;
			ancestor_q  <= res_anc_q;
			distance_q  <= res_dist_q;
			not_found_q <= res_nf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign ancestor  = ancestor_q;
	assign distance  = distance_q;
	assign not_found = not_found_q;

	`TALCA_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, pc_q == PC_DISPATCH, "accepted request did not start the sequencer")
	`TALCA_ASSERT_NOW(a_resp_from_finish, $rose(out_valid), $past(pc_q) == PC_FINISH, "response raised outside the finish step")
	`TALCA_ASSERT_NOW(a_insert_resp_clean, out_valid && !kind, ancestor == '0 && distance == '0 && !not_found, "insert response carries query data")
	`TALCA_ASSERT_NOW(a_nf_resp_clean, out_valid && not_found, ancestor == '0 && distance == '0 && kind, "not-found response carries data")

endmodule
